[hw/rtl/lru_k_frame_replacer_core_defines.svh]
// Assertion macros shared by the checker of the LRU-K replacer.
// Needs a clk and an rst signal in the scope of each use.
`ifndef LRU_K_FRAME_REPLACER_CORE_DEFINES_SVH
`define LRU_K_FRAME_REPLACER_CORE_DEFINES_SVH

// Same-cycle implication, switched off during reset.
`define LKR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off during reset.
`define LKR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define LKR_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/lkr_pkg.sv]
// Shared types and constants of the LRU-K frame replacer.
// No dependencies.
package lkr_pkg;

  localparam int FRAME_CNT_DEF  = 64;
  localparam int FRAME_W        = 8;
  localparam int CNT_W          = 8;
  localparam int STAMP_W        = 32;
  localparam int TOTAL_W        = 9;
  localparam logic [7:0] HIST_DEPTH_RST = 8'd2;

  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_EVICT  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [FRAME_W-1:0]   frame;
    logic                 mark;
    logic                 in_range;
  } item_t;

endpackage

[hw/rtl/lkr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/lkr_front.sv]
// Front end: takes input items, classifies the frame number and queues them.
// Depends on lkr_pkg.
module lkr_front #(
  parameter int FRAME_CNT = lkr_pkg::FRAME_CNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [15:0]   s_tdata,
  input  logic [1:0]    s_tuser,
  output logic          q_valid,
  input  logic          q_pop,
  output lkr_pkg::item_t q_item
);

  lkr_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  lkr_pkg::item_t incoming;

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    incoming.cmd      = lkr_pkg::cmd_t'(s_tuser);
    incoming.frame    = s_tdata[7:0];
    incoming.mark     = s_tdata[8];
    incoming.in_range = ({1'b0, s_tdata[7:0]} < 9'(FRAME_CNT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= incoming;
        wr_ptr        <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[hw/rtl/lkr_back.sv]
// Back end: carries out queued commands against the frame records.
// Depends on lkr_pkg and lkr_ram.
module lkr_back #(
  parameter int FRAME_CNT = lkr_pkg::FRAME_CNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     history_depth,
  input  logic           q_valid,
  output logic           q_pop,
  input  lkr_pkg::item_t q_item,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [23:0]    m_tdata
);

  localparam int AW = (FRAME_CNT > 1) ? $clog2(FRAME_CNT) : 1;
  localparam int RW = lkr_pkg::CNT_W + lkr_pkg::STAMP_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  lkr_pkg::item_t cur;
  logic [31:0] clock_now;
  logic [8:0]  total;
  logic [FRAME_CNT-1:0] tracked;
  logic [FRAME_CNT-1:0] full;
  logic [FRAME_CNT-1:0] evict;
  logic [AW-1:0] dat_idx;
  logic          nf_found, fl_found;
  logic [AW-1:0] nf_idx, fl_idx;
  logic [31:0]   nf_stamp, fl_stamp;
  logic          res_found;
  logic [7:0]    res_frame;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [7:0]    rd_cnt;
  logic [31:0]   rd_stamp;
  logic [AW-1:0] cidx;
  logic [7:0]    keff, c0, c1;
  logic          elig, nf_take, fl_take, nf_any, fl_any, last;
  logic [AW-1:0] nf_vic, fl_vic, vic;
  logic [AW-1:0] pidx;

  assign rd_cnt   = ram_rdata[RW-1:lkr_pkg::STAMP_W];
  assign rd_stamp = ram_rdata[lkr_pkg::STAMP_W-1:0];
  assign cidx     = cur.frame[AW-1:0];
  assign pidx     = q_item.frame[AW-1:0];
  assign q_pop    = (state == S_IDLE) && q_valid;

  lkr_ram #(.WIDTH(RW), .DEPTH(FRAME_CNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Record update for an access; a depth of zero behaves as one.
  always_comb begin
    keff = (history_depth == 8'd0) ? 8'd1 : history_depth;
    c0   = tracked[cidx] ? rd_cnt : 8'd0;
    c1   = (c0 == 8'hFF) ? c0 : c0 + 8'd1;
    ram_waddr = cidx;
    ram_we    = (state == S_READ);
    if (full[cidx]) begin
      ram_wdata = {rd_cnt, clock_now};
    end else if (!tracked[cidx] || (c1 >= keff)) begin
      ram_wdata = {c1, clock_now};
    end else begin
      ram_wdata = {c1, rd_stamp};
    end
  end

  always_comb begin
    if (state == S_SCAN) begin
      ram_raddr = dat_idx + AW'(1);
    end else if (q_item.cmd == lkr_pkg::CMD_EVICT) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = pidx;
    end
  end

  // Both classes are tracked in one pass; the short-history class wins.
  always_comb begin
    elig    = tracked[dat_idx] && evict[dat_idx];
    nf_take = elig && !full[dat_idx] && (rd_stamp < nf_stamp);
    fl_take = elig && full[dat_idx] && (rd_stamp < fl_stamp);
    nf_any  = nf_found || nf_take;
    fl_any  = fl_found || fl_take;
    nf_vic  = nf_take ? dat_idx : nf_idx;
    fl_vic  = fl_take ? dat_idx : fl_idx;
    vic     = nf_any ? nf_vic : fl_vic;
    last    = (dat_idx == AW'(FRAME_CNT - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clock_now <= '0;
      total     <= '0;
      tracked   <= '0;
      full      <= '0;
      evict     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_item;
            clock_now <= clock_now + 32'd1;
            res_found <= 1'b0;
            res_frame <= 8'd0;
            state     <= S_FIN;
            unique case (q_item.cmd)
              lkr_pkg::CMD_ACCESS: begin
                if (q_item.in_range) begin
                  state <= S_READ;
                end
              end
              lkr_pkg::CMD_MARK: begin
                if (q_item.in_range) begin
                  if (q_item.mark) begin
                    if (tracked[pidx] && !evict[pidx]) begin
                      evict[pidx] <= 1'b1;
                      total       <= total + 9'd1;
                    end
                  end else if (evict[pidx]) begin
                    evict[pidx] <= 1'b0;
                    total       <= total - 9'd1;
                  end
                end
              end
              lkr_pkg::CMD_REMOVE: begin
                if (q_item.in_range) begin
                  if (evict[pidx]) begin
                    total <= total - 9'd1;
                  end
                  tracked[pidx] <= 1'b0;
                  full[pidx]    <= 1'b0;
                  evict[pidx]   <= 1'b0;
                end
              end
              lkr_pkg::CMD_EVICT: begin
                dat_idx  <= '0;
                nf_found <= 1'b0;
                fl_found <= 1'b0;
                nf_stamp <= clock_now + 32'd1;
                fl_stamp <= clock_now + 32'd1;
                state    <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          tracked[cidx] <= 1'b1;
          if (!full[cidx] && (c1 >= keff)) begin
            full[cidx] <= 1'b1;
          end
          state <= S_FIN;
        end
        S_SCAN: begin
          if (nf_take) begin
            nf_found <= 1'b1;
            nf_idx   <= dat_idx;
            nf_stamp <= rd_stamp;
          end
          if (fl_take) begin
            fl_found <= 1'b1;
            fl_idx   <= dat_idx;
            fl_stamp <= rd_stamp;
          end
          dat_idx <= dat_idx + AW'(1);
          if (last) begin
            if (nf_any || fl_any) begin
              res_found    <= 1'b1;
              res_frame    <= 8'(vic);
              total        <= total - 9'd1;
              tracked[vic] <= 1'b0;
              full[vic]    <= 1'b0;
              evict[vic]   <= 1'b0;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, total, res_frame, res_found};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/lru_k_frame_replacer_core.sv]
// LRU-K frame replacer, top level: configuration register, front end and back end.
// Depends on lkr_pkg, lkr_front, lkr_back and lkr_ram.
//
// Input channel s_*: tuser carries the command (access, mark, remove, evict),
// tdata the frame number and the evictable mark. Every item gives exactly one
// result item on m_*: victim flag, victim frame and the evictable count.
// cfg_* writes k, the history depth, and may only be used while the block idles.
// Items wait in a two-entry queue, so the input side keeps taking items while
// a result waits on the output.
// From acceptance, an item passes the queue, then the idle state of the back end,
// then the finish state for mark, remove and out-of-range commands; an access
// also does one read and one write of the record memory before the finish, and
// an evict reads every record once through the single memory read port. Items
// are executed one at a time: a new item starts only after the result of the
// last one has gone into the output register, which waits for a free output.
// Reset clears all records, the clock, the evictable count and sets k to 2;
// no clearing pass is needed. If the receiver stalls, the result is held in the
// output register, the back end waits and the queue fills, then s_tready drops.
module lru_k_frame_replacer_core #(
  parameter int FRAME_CNT = lkr_pkg::FRAME_CNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // frame [7:0], make_evictable [8], zero [15:9]
  input  logic [1:0]  s_tuser,   // cmd [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // victim_found [0], victim_frame [8:1], evictable_count [17:9]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]     history_depth;
  logic           q_valid;
  logic           q_pop;
  lkr_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_depth <= lkr_pkg::HIST_DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      history_depth <= cfg_data;
    end
  end

  lkr_front #(.FRAME_CNT(FRAME_CNT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lkr_back #(.FRAME_CNT(FRAME_CNT)) u_back (
    .clk           (clk),
    .rst           (rst),
    .history_depth (history_depth),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule

[hw/rtl/lkr_checker.sv]
// Port-level checker for the LRU-K replacer, bound to the top level.
// Depends on lkr_pkg and lru_k_frame_replacer_core_defines.svh.
`include "lru_k_frame_replacer_core_defines.svh"

module lkr_checker #(
  parameter int FRAME_CNT = lkr_pkg::FRAME_CNT_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  `LKR_ASSERT_ALWAYS(a_rst_quiet, rst, !m_tvalid, "result valid straight after reset")
  `LKR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  `LKR_ASSERT_NOW(a_no_victim, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'd0, "victim frame without victim")
  `LKR_ASSERT_NOW(a_count_max, m_tvalid, m_tdata[17:9] <= 9'(FRAME_CNT), "evictable count above frame count")
  `LKR_ASSERT_NOW(a_victim_range, m_tvalid && m_tdata[0], {1'b0, m_tdata[8:1]} < 9'(FRAME_CNT), "victim out of range")

endmodule

bind lru_k_frame_replacer_core lkr_checker #(.FRAME_CNT(FRAME_CNT)) u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
